// ===== sv/gpc_pkg.sv =====
// gpc_pkg: types, constants and helpers for the gray piecewise colormap
// no dependencies
package gpc_pkg;

  localparam int unsigned MAX_COLORS_DEF = 16;
  localparam int unsigned CNT_W          = 5;
  localparam int unsigned CH_W           = 8;
  localparam int unsigned RECIP_SH       = 24;
  localparam int unsigned RECIP_W        = 25;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MAP  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic       command;
    logic [3:0] point_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } out_word_t;

  // classified word as passed from front to back
  typedef struct packed {
    logic        load;
    logic [3:0]  slot;
    logic [23:0] colour;
    logic [7:0]  gray;
  } job_t;

  // gray = sum/3 for sum <= 765: (sum*683)>>11
  function automatic logic [7:0] div3(input logic [9:0] sum);
    logic [20:0] p;
    p = 21'(sum) * 21'd683;
    return p[18:11];
  endfunction

endpackage

// ===== sv/gpc_front.sv =====
// gpc_front: accepts words, holds the colour count, classifies loads and pixels
// depends on gpc_pkg
module gpc_front #(
  parameter int unsigned MAX_COLORS = gpc_pkg::MAX_COLORS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [4:0]           cfg_data,
  input  logic                 in_valid,
  input  gpc_pkg::in_word_t    in_word,
  output logic                 in_stall,
  output logic                 q_valid,
  output gpc_pkg::job_t        q_job,
  input  logic                 q_full,
  output logic [8:0]           seg_w,
  output logic [gpc_pkg::RECIP_W-1:0] recip,
  output logic [8:0]           last
);
  localparam int unsigned AW = $clog2(MAX_COLORS);
  localparam int unsigned RW = gpc_pkg::RECIP_W;
  localparam int unsigned SH = gpc_pkg::RECIP_SH;

  logic [4:0] n_colours;
  logic [8:0] n_eff;
  logic [9:0] sum;
  logic       acc;
  logic [AW-1:0] t_idx;
  logic [MAX_COLORS-1:0][8:0]    w_tab;
  logic [MAX_COLORS-1:0][RW-1:0] m_tab;

  // width 256/k and its rounded-up reciprocal for k = n-1
  for (genvar k = 0; k < MAX_COLORS; k++) begin : g_tab
    localparam int unsigned WK = 256 / ((k == 0) ? 1 : k);
    localparam int unsigned MK = ((1 << SH) + WK - 1) / WK;
    assign w_tab[k] = 9'(WK);
    assign m_tab[k] = RW'(MK);
  end

  always_ff @(posedge clk) begin
    if (rst) n_colours <= 5'd2;
    else if (cfg_we) n_colours <= cfg_data;
  end

  always_comb begin
    if (n_colours < 5'd2) n_eff = 9'd2;
    else if (32'(n_colours) > MAX_COLORS) n_eff = 9'(MAX_COLORS);
    else n_eff = 9'(n_colours);
  end

  assign last  = n_eff - 9'd1;
  assign t_idx = AW'(last);
  assign seg_w = w_tab[t_idx];
  assign recip = m_tab[t_idx];

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;
  assign sum  = 10'(in_word.red_in) + 10'(in_word.green_in) + 10'(in_word.blue_in);

  // loads to a slot past the store are dropped here
  assign q_valid = acc && ((in_word.command == gpc_pkg::CMD_MAP)
                   || (32'(in_word.point_index) < MAX_COLORS));
  assign q_job.load   = in_word.command == gpc_pkg::CMD_LOAD;
  assign q_job.slot   = in_word.point_index;
  assign q_job.colour = {in_word.red_in, in_word.green_in, in_word.blue_in};
  assign q_job.gray   = gpc_pkg::div3(sum);
endmodule

// ===== sv/gpc_fifo.sv =====
// gpc_fifo: two-entry queue between front and back
// depends on gpc_pkg
module gpc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gpc_pkg::job_t push_job,
  output logic          full,
  output logic          pop_valid,
  output gpc_pkg::job_t pop_job,
  input  logic          pop
);
  gpc_pkg::job_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full      = cnt == 2'd2;
  assign pop_valid = cnt != 2'd0;
  assign pop_job   = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> pop_valid)
    else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count");
endmodule

// ===== sv/gpc_back.sv =====
// gpc_back: colour store, segment divide, blend pipeline and output register
// depends on gpc_pkg
module gpc_back #(
  parameter int unsigned MAX_COLORS = gpc_pkg::MAX_COLORS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [8:0]           seg_w,
  input  logic [gpc_pkg::RECIP_W-1:0] recip,
  input  logic [8:0]           last,
  input  logic                 j_valid,
  input  gpc_pkg::job_t        j_job,
  output logic                 j_pop,
  output logic                 out_valid,
  output gpc_pkg::out_word_t   out_word,
  input  logic                 out_stall
);
  localparam int unsigned AW = $clog2(MAX_COLORS);
  localparam int unsigned RW = gpc_pkg::RECIP_W;
  localparam int unsigned SH = gpc_pkg::RECIP_SH;
  localparam int unsigned PW = RW + 8;
  localparam int unsigned QW = RW + 17;

  logic [23:0] lo_mem [MAX_COLORS];
  logic [23:0] hi_mem [MAX_COLORS];

  logic          a_v, b_v, c_v, d_v;
  logic [PW-1:0] j_prod;
  logic [7:0]    a_gray, a_seg;
  logic [16:0]   a_prod;
  logic          a_tail;
  logic [AW-1:0] a_lo, a_hi, wr_addr;
  logic [23:0]   b_lo, b_hi, c_hi;
  logic [8:0]    b_off;
  logic          b_tail, c_tail;
  logic [16:0]   c_sum [3];
  logic          adv;

  // divide by segment width through its reciprocal
  function automatic logic [7:0] div_w(input logic [16:0] v, input logic [RW-1:0] m);
    logic [QW-1:0] p;
    p = QW'(v) * QW'(m);
    return p[SH+7:SH];
  endfunction

  // pipeline moves unless output is held
  assign adv     = !(d_v && out_stall);
  assign j_pop   = j_valid && adv;
  assign j_prod  = PW'(j_job.gray) * PW'(recip);
  assign wr_addr = AW'(j_job.slot);

  assign a_prod = 17'(a_seg) * 17'(seg_w);
  assign a_tail = 9'(a_seg) >= last;
  assign a_lo   = AW'(a_seg);
  assign a_hi   = a_tail ? AW'(last) : AW'(a_seg + 8'd1);

  // loads write in queue order
  always_ff @(posedge clk) begin
    if (j_pop && j_job.load) begin
      lo_mem[wr_addr] <= j_job.colour;
      hi_mem[wr_addr] <= j_job.colour;
    end
    if (adv) begin
      b_lo <= lo_mem[a_lo];
      b_hi <= hi_mem[a_hi];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_gray <= j_job.gray;
      a_seg  <= j_prod[SH+7:SH];
      b_off  <= 9'(17'(a_gray) - a_prod);
      b_tail <= a_tail;
      c_hi   <= b_hi;
      c_tail <= b_tail;
      for (int c = 0; c < 3; c++) begin
        c_sum[c] <= 17'(b_lo[8*c +: 8]) * 17'(seg_w - b_off)
                  + 17'(b_hi[8*c +: 8]) * 17'(b_off);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (c_tail) begin
        out_word <= gpc_pkg::out_word_t'(c_hi);
      end else begin
        out_word.red_out   <= div_w(c_sum[2], recip);
        out_word.green_out <= div_w(c_sum[1], recip);
        out_word.blue_out  <= div_w(c_sum[0], recip);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0; b_v <= 1'b0; c_v <= 1'b0; d_v <= 1'b0;
    end else if (adv) begin
      a_v <= j_pop && !j_job.load;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
    end
  end

  assign out_valid = d_v;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed under stall");
  a_pop_adv: assert property (@(posedge clk) disable iff (rst) j_pop |-> adv)
    else $error("pop while held");
  a_w_nonzero: assert property (@(posedge clk) disable iff (rst) seg_w != 9'd0)
    else $error("zero width");
endmodule

// ===== sv/gray_piecewise_colormap.sv =====
// gray_piecewise_colormap: top level, front classifier, queue, blend back end
// depends on gpc_pkg, gpc_front, gpc_fifo, gpc_back
//
//  channel  signals                        direction
//  in       in_valid in_stall in_word      into block
//  out      out_valid out_stall out_word   out of block
//  cfg      cfg_we cfg_data                into block
//
// one word per cycle sustained unless out_stall holds the output; a pixel passes
// the queue, then segment divide, store read, blend and divide by width.
// load words pass the queue in order and produce no output.
// reset clears pipeline, queue and count to two; the store is not cleared.
// out_stall with out_valid freezes all four stages; the two-entry queue then fills and raises in_stall.
module gray_piecewise_colormap #(
  parameter int unsigned MAX_COLORS = gpc_pkg::MAX_COLORS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  input  logic               in_valid,
  input  gpc_pkg::in_word_t  in_word,
  output logic               in_stall,
  output logic               out_valid,
  output gpc_pkg::out_word_t out_word,
  input  logic               out_stall
);
  logic q_push, q_full, q_pv, q_pop;
  gpc_pkg::job_t push_job, pop_job;
  logic [8:0] seg_w, last;
  logic [gpc_pkg::RECIP_W-1:0] recip;

  gpc_front #(.MAX_COLORS(MAX_COLORS)) u_front (
    .clk, .rst, .cfg_we, .cfg_data, .in_valid, .in_word, .in_stall,
    .q_valid(q_push), .q_job(push_job), .q_full,
    .seg_w, .recip, .last
  );

  gpc_fifo u_fifo (
    .clk, .rst, .push(q_push), .push_job, .full(q_full),
    .pop_valid(q_pv), .pop_job, .pop(q_pop)
  );

  gpc_back #(.MAX_COLORS(MAX_COLORS)) u_back (
    .clk, .rst, .seg_w, .recip, .last,
    .j_valid(q_pv), .j_job(pop_job), .j_pop(q_pop),
    .out_valid, .out_word, .out_stall
  );
endmodule
